/* design/utf8dec_pkg.sv */
// shared types and constants for the utf-8 to ucs-2 stream decoder
package utf8dec_pkg;

    // result status codes
    localparam logic [1:0] ST_CHAR     = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_REJECT   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // byte class limits
    localparam logic [7:0] B_ASCII_LIM = 8'h80;
    localparam logic [7:0] B_LEAD2_MIN = 8'hC2;
    localparam logic [7:0] B_LEAD3_MIN = 8'hE0;
    localparam logic [7:0] B_LEAD4_MIN = 8'hF0;
    localparam logic [7:0] B_E0_SECOND = 8'hA0;
    localparam logic [7:0] B_CONT_XOR  = 8'h80;
    localparam logic [7:0] B_CONT_LIM  = 8'h40;

    localparam logic [15:0] CAP_RESET  = 16'd1024;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // what the back end must emit for one queued entry
    typedef enum logic [1:0] {
        K_CHAR     = 2'd0,
        K_CHAR_END = 2'd1,
        K_CHAR_OVF = 2'd2,
        K_REJECT   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] code;
        logic [15:0] count;
    } t_entry;

endpackage

/* design/utf8dec_front.sv */
// front end: byte acceptance, utf-8 sequence tracking and classification
module utf8dec_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_byte_value,
    input  logic                   i_last_byte,
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_data,
    output logic                   o_push,
    output utf8dec_pkg::t_entry    o_entry
);
    import utf8dec_pkg::*;

    logic [15:0] r_capacity;
    logic [15:0] r_partial, n_partial;
    logic [1:0]  r_pending, n_pending;
    logic        r_need_high, n_need_high;
    logic [15:0] r_units, n_units;
    logic        r_skip, n_skip;

    logic        push_req;
    t_entry      entry;
    logic        done;
    logic        reject;
    logic [15:0] code;
    logic [7:0]  b_cont;
    logic [16:0] cnt;
    logic [15:0] shown;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    // decode step for the offered byte
    always_comb begin
        n_partial   = r_partial;
        n_pending   = r_pending;
        n_need_high = r_need_high;
        n_units     = r_units;
        n_skip      = r_skip;
        push_req    = 1'b0;
        entry       = '0;
        done        = 1'b0;
        reject      = 1'b0;
        code        = '0;
        b_cont      = i_byte_value ^ B_CONT_XOR;
        cnt         = {1'b0, r_units} + 17'd1;
        shown       = cnt[16] ? 16'hFFFF : cnt[15:0];

        if (r_skip) begin
            // dropping bytes until the string ends
            if (i_last_byte) begin
                n_partial   = '0;
                n_pending   = '0;
                n_need_high = 1'b0;
                n_units     = '0;
                n_skip      = 1'b0;
            end
        end else begin
            if (r_pending == 2'd0) begin
                // lead byte
                if (i_byte_value < B_ASCII_LIM) begin
                    code = {8'h00, i_byte_value};
                    done = 1'b1;
                end else if (i_byte_value < B_LEAD2_MIN || i_byte_value >= B_LEAD4_MIN) begin
                    reject = 1'b1;
                end else if (i_byte_value < B_LEAD3_MIN) begin
                    n_partial   = {5'b0, i_byte_value[4:0], 6'b0};
                    n_pending   = 2'd1;
                    n_need_high = 1'b0;
                end else begin
                    n_partial   = {i_byte_value[3:0], 12'b0};
                    n_pending   = 2'd2;
                    n_need_high = (i_byte_value == B_LEAD3_MIN);
                end
            end else begin
                // continuation byte
                if (b_cont >= B_CONT_LIM || (r_need_high && i_byte_value < B_E0_SECOND)) begin
                    reject = 1'b1;
                end else if (r_pending >= 2'd2) begin
                    n_partial   = r_partial | {4'b0, b_cont[5:0], 6'b0};
                    n_pending   = 2'd1;
                    n_need_high = 1'b0;
                end else begin
                    code        = r_partial | {10'b0, b_cont[5:0]};
                    n_partial   = '0;
                    n_pending   = 2'd0;
                    n_need_high = 1'b0;
                    done        = 1'b1;
                end
            end

            // string cut short
            if (!done && !reject && i_last_byte) begin
                reject = 1'b1;
            end

            if (reject) begin
                push_req    = 1'b1;
                entry.kind  = K_REJECT;
                entry.code  = '0;
                entry.count = r_units;
                n_partial   = '0;
                n_pending   = '0;
                n_need_high = 1'b0;
                n_units     = '0;
                n_skip      = !i_last_byte;
            end else if (done) begin
                push_req    = 1'b1;
                entry.code  = code;
                entry.count = shown;
                if (cnt > {1'b0, r_capacity}) begin
                    entry.kind  = K_CHAR_OVF;
                    n_partial   = '0;
                    n_pending   = '0;
                    n_need_high = 1'b0;
                    n_units     = '0;
                    n_skip      = !i_last_byte;
                end else if (i_last_byte) begin
                    entry.kind  = K_CHAR_END;
                    n_partial   = '0;
                    n_pending   = '0;
                    n_need_high = 1'b0;
                    n_units     = '0;
                    n_skip      = 1'b0;
                end else begin
                    entry.kind  = K_CHAR;
                    n_units     = cnt[15:0];
                end
            end
        end
    end

    // decode state, advanced once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_pending   <= '0;
            r_need_high <= 1'b0;
            r_units     <= '0;
            r_skip      <= 1'b0;
        end else if (i_accept) begin
            r_partial   <= n_partial;
            r_pending   <= n_pending;
            r_need_high <= n_need_high;
            r_units     <= n_units;
            r_skip      <= n_skip;
        end
    end

    assign o_push  = i_accept && push_req;
    assign o_entry = entry;

endmodule

/* design/utf8dec_fifo.sv */
// short queue of classified entries between front and back
module utf8dec_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  utf8dec_pkg::t_entry    i_entry,
    input  logic                   i_pop,
    output utf8dec_pkg::t_entry    o_entry,
    output logic                   o_empty,
    output logic                   o_full
);
    import utf8dec_pkg::*;

    t_entry               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_entry = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));

endmodule

/* design/utf8dec_back.sv */
// back end: expands queued entries into result transactions
module utf8dec_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  utf8dec_pkg::t_entry    i_entry,
    input  logic                   i_empty,
    output logic                   o_pop,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [15:0]            o_code_unit,
    output logic [1:0]             o_status,
    output logic [15:0]            o_unit_count,
    output logic                   o_run_end
);
    import utf8dec_pkg::*;

    logic        r_valid;
    logic [15:0] r_code;
    logic [1:0]  r_status;
    logic [15:0] r_count;
    logic        r_run_end;

    // pending second result of a two-result entry
    logic        r_second;
    logic [1:0]  r_sec_status;
    logic [15:0] r_sec_count;

    logic        load;

    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && !r_second && !i_empty;

    // control: output valid and second-result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            if (r_second) begin
                r_valid  <= 1'b1;
                r_second <= 1'b0;
            end else if (!i_empty) begin
                r_valid  <= 1'b1;
                r_second <= (i_entry.kind == K_CHAR_END) || (i_entry.kind == K_CHAR_OVF);
            end else begin
                r_valid  <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_second) begin
                r_code    <= '0;
                r_status  <= r_sec_status;
                r_count   <= r_sec_count;
                r_run_end <= 1'b1;
            end else if (!i_empty) begin
                r_code      <= i_entry.code;
                r_count     <= i_entry.count;
                r_sec_count <= i_entry.count;
                case (i_entry.kind)
                    K_CHAR: begin
                        r_status     <= ST_CHAR;
                        r_run_end    <= 1'b0;
                        r_sec_status <= ST_END;
                    end
                    K_CHAR_END: begin
                        r_status     <= ST_CHAR;
                        r_run_end    <= 1'b0;
                        r_sec_status <= ST_END;
                    end
                    K_CHAR_OVF: begin
                        r_status     <= ST_CHAR;
                        r_run_end    <= 1'b0;
                        r_sec_status <= ST_OVERFLOW;
                    end
                    K_REJECT: begin
                        r_status     <= ST_REJECT;
                        r_run_end    <= 1'b1;
                        r_sec_status <= ST_REJECT;
                    end
                    default: begin
                        r_status     <= ST_REJECT;
                        r_run_end    <= 1'b1;
                        r_sec_status <= ST_REJECT;
                    end
                endcase
            end
        end
    end

    assign o_out_valid  = r_valid;
    assign o_code_unit  = r_code;
    assign o_status     = r_status;
    assign o_unit_count = r_count;
    assign o_run_end    = r_run_end;

endmodule

/* design/utf8_to_ucs2_stream_decoder_top.sv */
// top level of the utf-8 to ucs-2 stream decoder
//
// Input channel: one utf-8 byte per transaction (i_byte_value, with
// i_last_byte set on the final byte of a string), accepted when i_in_valid
// is high and o_in_stall is low. Output channel: one result per transaction
// (code unit, status, unit count, run end), taken when o_out_valid is high
// and i_out_stall is low. i_cfg_we writes i_cfg_data into the capacity
// register (reset value 1024).
// Throughput: one byte per cycle while o_in_stall is low. A byte that
// completes a character at the end of a string, or passes the capacity,
// gives two results, which leave the output register one after the other;
// a four-entry queue between the decoder and the output stage absorbs this.
// A byte's queue entry is written when the byte is accepted; the output
// register is loaded from the queue head afterwards, once it is free.
// Reset clears the decode state, the queue and the output valid.
// While the receiver stalls, the output holds; the decoder keeps taking
// bytes until the queue is full, then raises o_in_stall.
module utf8_to_ucs2_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_code_unit,
    output logic [1:0]  o_status,
    output logic [15:0] o_unit_count,
    output logic        o_run_end
);
    import utf8dec_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   empty;
    logic   full;
    t_entry push_entry;
    t_entry head_entry;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    // byte decode and classification
    utf8dec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // decoupling queue
    utf8dec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_empty (empty),
        .o_full  (full)
    );

    // result expansion and output register
    utf8dec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (head_entry),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_code_unit  (o_code_unit),
        .o_status     (o_status),
        .o_unit_count (o_unit_count),
        .o_run_end    (o_run_end)
    );

endmodule

/* design/utf8dec_checker.sv */
// port-level checks for the decoder top level, with bind
module utf8dec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_code_unit,
    input logic [1:0]  o_status,
    input logic [15:0] o_unit_count,
    input logic        o_run_end
);
    import utf8dec_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_code_unit)
            && $stable(o_status) && $stable(o_unit_count) && $stable(o_run_end))
        else $error("stalled result changed");

    // only character results leave the run open
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_end == (o_status != ST_CHAR)))
        else $error("run end flag disagrees with status");

    // non-character results carry a zero code unit
    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_CHAR |-> o_code_unit == 16'd0)
        else $error("non-character result with nonzero code unit");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind utf8_to_ucs2_stream_decoder_top utf8dec_checker u_utf8dec_checker (.*);

/* dv/tb.sv */
// testbench for the utf-8 to ucs-2 stream decoder: table-driven and random byte streams
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8dec_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_IDLE      = 17;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int RAND_PHASES   = 4;
    localparam int PHASE_BYTES   = 150;
    localparam int MAX_SHOWN     = 10;

    // one decoded result as it leaves the block
    typedef struct packed {
        logic [15:0] code;
        logic [1:0]  status;
        logic [15:0] count;
        logic        run_end;
    } t_ucs_res;

    // one line of the directed table: a capacity write or a byte
    typedef struct {
        logic        is_cfg;
        logic [15:0] cap;
        logic [7:0]  b;
        logic        lst;
        int          n;
        t_ucs_res    e0;
        t_ucs_res    e1;
    } t_stim_row;

    localparam t_ucs_res NO_RES = '0;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_last_byte  = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [15:0] i_cfg_data   = 16'h0000;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_code_unit;
    logic [1:0]  o_status;
    logic [15:0] o_unit_count;
    logic        o_run_end;

    utf8_to_ucs2_stream_decoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code_unit  (o_code_unit),
        .o_status     (o_status),
        .o_unit_count (o_unit_count),
        .o_run_end    (o_run_end)
    );

    // decoder shadow state
    logic [15:0] cap_r   = CAP_RESET;
    logic [15:0] part_r  = '0;
    logic [1:0]  pend_r  = '0;
    logic        high_r  = 1'b0;
    logic [15:0] units_r = '0;
    logic        skip_r  = 1'b0;

    t_ucs_res  step_units[$];
    t_ucs_res  exp_units[$];
    t_stim_row dir_rows[$];
    logic [7:0] str_bytes[$];

    int n_err  = 0;
    int cycles = 0;
    bit in_busy = 1'b0;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_ucs_res ucs_res(input logic [15:0] code, input logic [1:0] st,
                                         input logic [15:0] cnt, input logic fin);
        t_ucs_res r;
        r.code    = code;
        r.status  = st;
        r.count   = cnt;
        r.run_end = fin;
        return r;
    endfunction

    function automatic t_stim_row byte_row(input logic [7:0] b, input logic lst, input int n,
                                           input t_ucs_res e0, input t_ucs_res e1);
        t_stim_row r;
        r.is_cfg = 1'b0;
        r.cap    = '0;
        r.b      = b;
        r.lst    = lst;
        r.n      = n;
        r.e0     = e0;
        r.e1     = e1;
        return r;
    endfunction

    function automatic t_stim_row cap_row(input logic [15:0] cap);
        t_stim_row r;
        r        = byte_row(8'h00, 1'b0, 0, NO_RES, NO_RES);
        r.is_cfg = 1'b1;
        r.cap    = cap;
        return r;
    endfunction

    // clear the run; keep_skip drops bytes until the string's last byte
    function automatic void end_run(input logic keep_skip);
        part_r  = '0;
        pend_r  = '0;
        high_r  = 1'b0;
        units_r = '0;
        skip_r  = keep_skip;
    endfunction

    // predicts the results of one byte into step_units
    function automatic void decode_byte(input logic [7:0] b, input logic lst);
        logic        done;
        logic        reject;
        logic [15:0] code;
        logic [7:0]  cont;
        logic [16:0] cnt;
        logic [15:0] shown;
        done   = 1'b0;
        reject = 1'b0;
        code   = '0;
        cont   = b ^ B_CONT_XOR;
        step_units.delete();
        if (skip_r) begin
            if (lst) end_run(1'b0);
            return;
        end
        // lead byte or continuation
        if (pend_r == 2'd0) begin
            if (b < B_ASCII_LIM) begin
                code = {8'h00, b};
                done = 1'b1;
            end else if (b < B_LEAD2_MIN || b >= B_LEAD4_MIN) begin
                reject = 1'b1;
            end else if (b < B_LEAD3_MIN) begin
                part_r = {5'd0, b[4:0], 6'd0};
                pend_r = 2'd1;
                high_r = 1'b0;
            end else begin
                part_r = {b[3:0], 12'd0};
                pend_r = 2'd2;
                high_r = (b == B_LEAD3_MIN);
            end
        end else begin
            if (cont >= B_CONT_LIM || (high_r && b < B_E0_SECOND)) begin
                reject = 1'b1;
            end else if (pend_r >= 2'd2) begin
                part_r = part_r | {4'd0, cont[5:0], 6'd0};
                pend_r = 2'd1;
                high_r = 1'b0;
            end else begin
                code   = part_r | {10'd0, cont[5:0]};
                pend_r = 2'd0;
                part_r = '0;
                high_r = 1'b0;
                done   = 1'b1;
            end
        end
        // string ends inside a sequence
        if (!done && !reject && lst) reject = 1'b1;
        if (reject) begin
            step_units.push_back(ucs_res(16'h0000, ST_REJECT, units_r, 1'b1));
            end_run(!lst);
            return;
        end
        if (done) begin
            cnt   = {1'b0, units_r} + 17'd1;
            shown = cnt[16] ? 16'hFFFF : cnt[15:0];
            step_units.push_back(ucs_res(code, ST_CHAR, shown, 1'b0));
            if (cnt > {1'b0, cap_r}) begin
                step_units.push_back(ucs_res(16'h0000, ST_OVERFLOW, shown, 1'b1));
                end_run(!lst);
                return;
            end
            units_r = cnt[15:0];
            if (lst) begin
                step_units.push_back(ucs_res(16'h0000, ST_END, cnt[15:0], 1'b1));
                end_run(1'b0);
            end
        end
    endfunction

    // one byte transaction; predicted results are queued at the accept edge
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic predicted);
        int gap;
        gap = in_busy ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_byte_value <= b;
        i_last_byte  <= lst;
        do @(posedge i_clk); while (!(i_in_valid === 1'b1 && o_in_stall === 1'b0));
        decode_byte(b, lst);
        if (predicted) begin
            foreach (step_units[k]) exp_units.push_back(step_units[k]);
        end
    endtask

    // hold the sender until every expected result is out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (exp_units.size() != 0);
    endtask

    task automatic set_capacity(input logic [15:0] cap);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        cap_r = cap;
        i_cfg_we <= 1'b0;
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial begin
        t_ucs_res got;
        t_ucs_res want;
        int       hold;
        int       taken;
        bit       out_busy;
        taken    = 0;
        out_busy = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 20 == 0) out_busy = ($urandom_range(0, 2) != 0);
            hold = out_busy ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
            got = {o_code_unit, o_status, o_unit_count, o_run_end};
            taken++;
            if (exp_units.size() == 0) begin
                n_err++;
                if (n_err <= MAX_SHOWN)
                    $display("unexpected result: code %h status %0d count %0d end %0d",
                             got.code, got.status, got.count, got.run_end);
            end else begin
                want = exp_units.pop_front();
                if (got.code !== want.code || got.status !== want.status ||
                    got.count !== want.count || got.run_end !== want.run_end) begin
                    n_err++;
                    if (n_err <= MAX_SHOWN)
                        $display("mismatch: want code %h status %0d count %0d end %0d, %s",
                                 want.code, want.status, want.count, want.run_end,
                                 $sformatf("got code %h status %0d count %0d end %0d",
                                           got.code, got.status, got.count, got.run_end));
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [15:0] phase_cap[RAND_PHASES];
        logic [7:0]  lead;
        int          kind;
        int          nch;
        int          sent;

        // directed table: extremes, every byte class, each error path
        dir_rows.push_back(byte_row(8'h00, 1'b0, 1, ucs_res(16'h0000, ST_CHAR, 16'd1, 1'b0),
                                    NO_RES));
        dir_rows.push_back(byte_row(8'h7F, 1'b0, 1, ucs_res(16'h007F, ST_CHAR, 16'd2, 1'b0),
                                    NO_RES));
        dir_rows.push_back(byte_row(8'hC2, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'h80, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'hDF, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'hBF, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'hE0, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'hA0, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'h80, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'hEF, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'hBF, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'hBF, 1'b1, -1, NO_RES, NO_RES));
        // stray continuation as lead, at the string end
        dir_rows.push_back(byte_row(8'h80, 1'b1, 1, ucs_res(16'h0000, ST_REJECT, 16'd0, 1'b1),
                                    NO_RES));
        // overlong two-byte lead, then bytes dropped up to the last one
        dir_rows.push_back(byte_row(8'hC1, 1'b0, 1, ucs_res(16'h0000, ST_REJECT, 16'd0, 1'b1),
                                    NO_RES));
        dir_rows.push_back(byte_row(8'h41, 1'b1, 0, NO_RES, NO_RES));
        // four-byte and invalid leads
        dir_rows.push_back(byte_row(8'hF0, 1'b1, 1, ucs_res(16'h0000, ST_REJECT, 16'd0, 1'b1),
                                    NO_RES));
        dir_rows.push_back(byte_row(8'hFF, 1'b1, 1, ucs_res(16'h0000, ST_REJECT, 16'd0, 1'b1),
                                    NO_RES));
        // overlong three-byte form
        dir_rows.push_back(byte_row(8'hE0, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'h9F, 1'b1, -1, NO_RES, NO_RES));
        // bad continuation byte mid-string
        dir_rows.push_back(byte_row(8'hC2, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'hC0, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'h00, 1'b1, 0, NO_RES, NO_RES));
        // surrogate code point passes through
        dir_rows.push_back(byte_row(8'hED, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'hA0, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'h80, 1'b1, -1, NO_RES, NO_RES));
        // sequence cut short by the string end
        dir_rows.push_back(byte_row(8'hC3, 1'b1, -1, NO_RES, NO_RES));
        // zero capacity: first unit overflows
        dir_rows.push_back(cap_row(16'h0000));
        dir_rows.push_back(byte_row(8'h41, 1'b1, 2, ucs_res(16'h0041, ST_CHAR, 16'd1, 1'b0),
                                    ucs_res(16'h0000, ST_OVERFLOW, 16'd1, 1'b1)));
        // overflow on the last byte wins over the clean end
        dir_rows.push_back(cap_row(16'd2));
        dir_rows.push_back(byte_row(8'h7F, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'h7F, 1'b0, -1, NO_RES, NO_RES));
        dir_rows.push_back(byte_row(8'h7F, 1'b1, -1, NO_RES, NO_RES));

        // reset
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                set_capacity(dir_rows[r].cap);
            end else begin
                in_busy = ($urandom_range(0, 1) != 0);
                send_byte(dir_rows[r].b, dir_rows[r].lst, dir_rows[r].n < 0);
                if (dir_rows[r].n >= 1) exp_units.push_back(dir_rows[r].e0);
                if (dir_rows[r].n >= 2) exp_units.push_back(dir_rows[r].e1);
            end
        end

        // random strings, mostly well formed
        phase_cap[0] = 16'($urandom_range(1, 8));
        phase_cap[1] = 16'hFFFF;
        phase_cap[2] = 16'h0000;
        phase_cap[3] = 16'($urandom_range(2, 30));
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_capacity(phase_cap[ph]);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                kind = $urandom_range(0, 99);
                str_bytes.delete();
                if (kind < 90) begin
                    nch = $urandom_range(1, 6);
                    repeat (nch) begin
                        case ($urandom_range(0, 2))
                            0: begin
                                str_bytes.push_back(8'($urandom_range(0, 127)));
                            end
                            1: begin
                                str_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                                str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                            end
                            default: begin
                                lead = 8'($urandom_range(8'hE0, 8'hEF));
                                str_bytes.push_back(lead);
                                if (lead == B_LEAD3_MIN)
                                    str_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                                else
                                    str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                                str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                            end
                        endcase
                    end
                    // broken sequence: one byte replaced or the tail cut
                    if (kind >= 75) begin
                        if ($urandom_range(0, 1) != 0)
                            str_bytes[$urandom_range(0, str_bytes.size() - 1)] =
                                8'($urandom_range(0, 255));
                        else if (str_bytes.size() > 1)
                            void'(str_bytes.pop_back());
                    end
                end else begin
                    // raw noise
                    repeat ($urandom_range(1, 5)) str_bytes.push_back(8'($urandom_range(0, 255)));
                end
                in_busy = ($urandom_range(0, 3) != 0);
                foreach (str_bytes[i])
                    send_byte(str_bytes[i], i == str_bytes.size() - 1, 1'b1);
                sent += str_bytes.size();
                // sender waits for the output to run dry now and then
                if ($urandom_range(0, 29) == 0) drain();
            end
        end

        // wind down
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_err == 0 && exp_units.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
